>>> rtl/dpalu_pkg.sv
// Package for the data-processing ALU: opcode and shift-type codes,
// flag bit positions and the control word that rides down the pipeline.
// No dependencies; imported by the ALU top level and its checker.
`default_nettype none

package dpalu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FlagW = 4;

  // Flag bit positions in an NZCV word
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // Per-beat control carried alongside the datapath
  typedef struct packed {
    op_t              op;
    logic             set_flags;
    logic             dest_is_pc;
    logic             psr;
    logic [FlagW-1:0] flags;
  } ctl_t;

  // Compare opcodes TST, TEQ, CMP, CMN
  function automatic logic is_compare(input op_t op);
    logic [3:0] code;
    code = op;
    return (code[3:2] == 2'b10);
  endfunction

endpackage

`default_nettype wire

>>> rtl/arm_data_processing_alu.sv
// Data-processing ALU with barrel shifter, four register stages.
// Depends on dpalu_pkg (opcode, shift and control types).
//
// Usage:
//   Input channel in_valid/in_ready carries one decoded data-processing
//   instruction per beat: opcode, operand form, S bit, destination-is-PC,
//   shifter field, operand values and the current NZCV flags.
//   Result channel out_valid/out_ready returns one beat per input beat, in
//   order: result, write enable, new flags, status-restore and PSR-transfer
//   marks.
//   Operand decode feeds stage 1, then barrel shift, 32-bit add/logic and
//   flag forming fill stages 2 to 4; out_valid is the stage 4 valid bit.
//   One beat is taken every cycle while the receiver keeps out_ready high,
//   since each stage reloads in the cycle its beat moves on.
//   When the receiver stalls, each stage holds its beat and a stage with a
//   bubble still fills from the one before, so in_ready falls only once all
//   four stages are full and out_ready is low.
//   Synchronous reset (rst_n low) empties every stage; out_valid is low in
//   the cycle after reset.
`default_nettype none

module arm_data_processing_alu (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [3:0]                   in_mode,
  input  wire                          in_immediate_form,
  input  wire                          in_set_flags,
  input  wire                          in_dest_is_pc,
  input  wire  [11:0]                  in_shifter_field,
  input  wire  [dpalu_pkg::DataW-1:0]  in_first_operand,
  input  wire  [dpalu_pkg::DataW-1:0]  in_second_register,
  input  wire  [7:0]                   in_shift_register_byte,
  input  wire  [dpalu_pkg::FlagW-1:0]  in_flags_in,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [dpalu_pkg::DataW-1:0]  out_result,
  output logic                         out_write_result,
  output logic [dpalu_pkg::FlagW-1:0]  out_flags_out,
  output logic                         out_restore_status,
  output logic                         out_psr_transfer
);

  import dpalu_pkg::*;

  // Stage enables: a stage loads when it is empty or its beat moves on
  logic en1, en2, en3, en4;

  // Stage 1: decoded shifter operands
  logic              s1_valid_r;
  ctl_t              s1_ctl_r,  s1_ctl_nxt;
  logic [DataW-1:0]  s1_a_r;
  logic [DataW-1:0]  s1_val_r,  s1_val_nxt;
  shift_t            s1_type_r, s1_type_nxt;
  logic [7:0]        s1_amt_r,  s1_amt_nxt;
  logic              s1_rrx_r,  s1_rrx_nxt;

  // Stage 2: shifted operand and shifter carry
  logic              s2_valid_r;
  ctl_t              s2_ctl_r;
  logic [DataW-1:0]  s2_a_r;
  logic [DataW-1:0]  s2_b_r,    s2_b_nxt;
  logic              s2_sc_r,   s2_sc_nxt;

  // Stage 3: ALU result with carry and overflow
  logic              s3_valid_r;
  ctl_t              s3_ctl_r;
  logic [DataW-1:0]  s3_res_r,  s3_res_nxt;
  logic              s3_c_r,    s3_c_nxt;
  logic              s3_v_r,    s3_v_nxt;

  // Stage 4: output register
  logic              out_valid_r;
  logic [DataW-1:0]  out_result_r,  out_result_nxt;
  logic              out_write_r,   out_write_nxt;
  logic [FlagW-1:0]  out_flags_r,   out_flags_nxt;
  logic              out_restore_r, out_restore_nxt;
  logic              out_psr_r,     out_psr_nxt;

  assign en4 = !out_valid_r || out_ready;
  assign en3 = !s3_valid_r  || en4;
  assign en2 = !s2_valid_r  || en3;
  assign en1 = !s1_valid_r  || en2;
  assign in_ready = en1;

  // Decode the operand form into value, shift type and amount
  logic [4:0] imm_amt;
  shift_t     reg_type;

  always_comb begin
    imm_amt  = in_shifter_field[11:7];
    reg_type = shift_t'(in_shifter_field[6:5]);

    s1_ctl_nxt.op         = op_t'(in_mode);
    s1_ctl_nxt.set_flags  = in_set_flags;
    s1_ctl_nxt.dest_is_pc = in_dest_is_pc;
    s1_ctl_nxt.psr        = is_compare(op_t'(in_mode)) && !in_set_flags;
    s1_ctl_nxt.flags      = in_flags_in;

    s1_rrx_nxt = 1'b0;
    if (in_immediate_form) begin
      // imm8 rotated right by twice the rotate field
      s1_val_nxt  = {24'd0, in_shifter_field[7:0]};
      s1_type_nxt = SH_ROR;
      s1_amt_nxt  = {3'd0, in_shifter_field[11:8], 1'b0};
    end else if (in_shifter_field[4]) begin
      s1_val_nxt  = in_second_register;
      s1_type_nxt = reg_type;
      s1_amt_nxt  = in_shift_register_byte;
    end else begin
      s1_val_nxt  = in_second_register;
      s1_type_nxt = reg_type;
      s1_amt_nxt  = {3'd0, imm_amt};
      if (imm_amt == 5'd0) begin
        // ROR #0 is RRX; LSR #0 and ASR #0 mean a shift by 32
        if (reg_type == SH_ROR) begin
          s1_rrx_nxt = 1'b1;
        end else if (reg_type == SH_LSR || reg_type == SH_ASR) begin
          s1_amt_nxt = 8'd32;
        end
      end
    end
  end

  // Barrel shifter
  logic               cin2;
  logic               big_amt;
  logic               amt_is_32;
  logic [DataW:0]     lsl_w;
  logic [DataW:0]     lsr_w;
  logic signed [DataW:0] asr_w;
  logic [2*DataW-1:0] ror_w;

  always_comb begin
    cin2      = s1_ctl_r.flags[FlagC];
    big_amt   = |s1_amt_r[7:5];
    amt_is_32 = (s1_amt_r == 8'd32);
    lsl_w     = {1'b0, s1_val_r} << s1_amt_r[4:0];
    lsr_w     = {s1_val_r, 1'b0} >> s1_amt_r[4:0];
    asr_w     = $signed({s1_val_r, 1'b0}) >>> s1_amt_r[4:0];
    ror_w     = {s1_val_r, s1_val_r} >> s1_amt_r[4:0];

    if (s1_rrx_r) begin
      s2_b_nxt  = {cin2, s1_val_r[DataW-1:1]};
      s2_sc_nxt = s1_val_r[0];
    end else if (s1_amt_r == 8'd0) begin
      s2_b_nxt  = s1_val_r;
      s2_sc_nxt = cin2;
    end else begin
      case (s1_type_r)
        SH_LSL: begin
          if (!big_amt) begin
            s2_b_nxt  = lsl_w[DataW-1:0];
            s2_sc_nxt = lsl_w[DataW];
          end else begin
            s2_b_nxt  = '0;
            s2_sc_nxt = amt_is_32 && s1_val_r[0];
          end
        end
        SH_LSR: begin
          if (!big_amt) begin
            s2_b_nxt  = lsr_w[DataW:1];
            s2_sc_nxt = lsr_w[0];
          end else begin
            s2_b_nxt  = '0;
            s2_sc_nxt = amt_is_32 && s1_val_r[DataW-1];
          end
        end
        SH_ASR: begin
          if (!big_amt) begin
            s2_b_nxt  = asr_w[DataW:1];
            s2_sc_nxt = asr_w[0];
          end else begin
            s2_b_nxt  = {DataW{s1_val_r[DataW-1]}};
            s2_sc_nxt = s1_val_r[DataW-1];
          end
        end
        default: begin
          // Rotate by the amount mod 32; carry is the new top bit
          s2_b_nxt  = ror_w[DataW-1:0];
          s2_sc_nxt = ror_w[DataW-1];
        end
      endcase
    end
  end

  // ALU: one 33-bit adder shared by the arithmetic opcodes
  logic [DataW-1:0] add_x, add_y, ovf_w;
  logic             add_ci, logical, cin3;
  logic [DataW:0]   sum_w;

  always_comb begin
    cin3    = s2_ctl_r.flags[FlagC];
    add_x   = s2_a_r;
    add_y   = s2_b_r;
    add_ci  = 1'b0;
    logical = 1'b1;
    case (s2_ctl_r.op) inside
      OP_SUB, OP_CMP: begin
        add_y = ~s2_b_r;  add_ci = 1'b1;  logical = 1'b0;
      end
      OP_RSB: begin
        add_x = s2_b_r;  add_y = ~s2_a_r;  add_ci = 1'b1;  logical = 1'b0;
      end
      OP_ADD, OP_CMN: begin
        logical = 1'b0;
      end
      OP_ADC: begin
        add_ci = cin3;  logical = 1'b0;
      end
      OP_SBC: begin
        add_y = ~s2_b_r;  add_ci = cin3;  logical = 1'b0;
      end
      OP_RSC: begin
        add_x = s2_b_r;  add_y = ~s2_a_r;  add_ci = cin3;  logical = 1'b0;
      end
      default: begin
      end
    endcase

    sum_w = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_ci};
    ovf_w = ~(add_x ^ add_y) & (add_x ^ sum_w[DataW-1:0]);

    case (s2_ctl_r.op) inside
      OP_AND, OP_TST: s3_res_nxt = s2_a_r & s2_b_r;
      OP_EOR, OP_TEQ: s3_res_nxt = s2_a_r ^ s2_b_r;
      OP_ORR:         s3_res_nxt = s2_a_r | s2_b_r;
      OP_MOV:         s3_res_nxt = s2_b_r;
      OP_BIC:         s3_res_nxt = s2_a_r & ~s2_b_r;
      OP_MVN:         s3_res_nxt = ~s2_b_r;
      default:        s3_res_nxt = sum_w[DataW-1:0];
    endcase

    // Logical opcodes take the shifter carry and keep V
    if (logical) begin
      s3_c_nxt = s2_sc_r;
      s3_v_nxt = s2_ctl_r.flags[FlagV];
    end else begin
      s3_c_nxt = sum_w[DataW];
      s3_v_nxt = ovf_w[DataW-1];
    end
  end

  // Form write-back, status marks and new flags
  logic cmp4, update4;

  always_comb begin
    cmp4    = is_compare(s3_ctl_r.op);
    update4 = cmp4 || (s3_ctl_r.set_flags && !s3_ctl_r.dest_is_pc);
    if (s3_ctl_r.psr) begin
      out_result_nxt  = '0;
      out_write_nxt   = 1'b0;
      out_flags_nxt   = s3_ctl_r.flags;
      out_restore_nxt = 1'b0;
      out_psr_nxt     = 1'b1;
    end else begin
      out_result_nxt  = s3_res_r;
      out_write_nxt   = !cmp4;
      out_restore_nxt = s3_ctl_r.set_flags && s3_ctl_r.dest_is_pc;
      out_psr_nxt     = 1'b0;
      if (update4) begin
        out_flags_nxt = {s3_res_r[DataW-1], (s3_res_r == '0), s3_c_r, s3_v_r};
      end else begin
        out_flags_nxt = s3_ctl_r.flags;
      end
    end
  end

  // Valid bits: clear on reset, advance with their stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r  <= in_valid;
      if (en2) s2_valid_r  <= s1_valid_r;
      if (en3) s3_valid_r  <= s2_valid_r;
      if (en4) out_valid_r <= s3_valid_r;
    end
  end

  // Payload registers: load when the stage advances
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ctl_r  <= s1_ctl_nxt;
      s1_a_r    <= in_first_operand;
      s1_val_r  <= s1_val_nxt;
      s1_type_r <= s1_type_nxt;
      s1_amt_r  <= s1_amt_nxt;
      s1_rrx_r  <= s1_rrx_nxt;
    end
    if (en2) begin
      s2_ctl_r <= s1_ctl_r;
      s2_a_r   <= s1_a_r;
      s2_b_r   <= s2_b_nxt;
      s2_sc_r  <= s2_sc_nxt;
    end
    if (en3) begin
      s3_ctl_r <= s2_ctl_r;
      s3_res_r <= s3_res_nxt;
      s3_c_r   <= s3_c_nxt;
      s3_v_r   <= s3_v_nxt;
    end
    if (en4) begin
      out_result_r  <= out_result_nxt;
      out_write_r   <= out_write_nxt;
      out_flags_r   <= out_flags_nxt;
      out_restore_r <= out_restore_nxt;
      out_psr_r     <= out_psr_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_write_result   = out_write_r;
  assign out_flags_out      = out_flags_r;
  assign out_restore_status = out_restore_r;
  assign out_psr_transfer   = out_psr_r;

endmodule

`default_nettype wire

>>> rtl/dpalu_checker.sv
// Port-level checker for the data-processing ALU, bound to its top level.
// Depends on dpalu_pkg for widths and flag positions.
`default_nettype none

module dpalu_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [dpalu_pkg::DataW-1:0]   out_result,
  input wire                          out_write_result,
  input wire [dpalu_pkg::FlagW-1:0]   out_flags_out,
  input wire                          out_restore_status,
  input wire                          out_psr_transfer
);

  import dpalu_pkg::*;

  // Reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result)
      && $stable(out_flags_out))
    else $error("stalled result beat changed");

  // A status transfer carries no ALU action
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_psr_transfer |->
      out_result == '0 && !out_write_result && !out_restore_status)
    else $error("status transfer beat carries ALU fields");

  // Input is back-pressured only when the receiver stalls a held beat
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low while output drains");

endmodule

bind arm_data_processing_alu dpalu_checker u_dpalu_checker (.*);

`default_nettype wire
